// ===== src/tga_pkg.sv =====
package tga_pkg;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SKIP,
		PH_RAW,
		PH_PKTHDR,
		PH_PKTDATA,
		PH_FINISHED
	} phase_t;

	typedef enum logic [2:0] {
		ST_PIXELS     = 3'd0,
		ST_BAD_TYPE   = 3'd1,
		ST_COLORMAP   = 3'd2,
		ST_BAD_DEPTH  = 3'd3,
		ST_GRAY_DEPTH = 3'd4
	} status_t;

	localparam logic [7:0] TYPE_RGB   = 8'd2;
	localparam logic [7:0] TYPE_GRAY  = 8'd3;
	localparam logic [7:0] TYPE_RLE   = 8'd10;

	localparam logic [7:0] DEPTH_GRAY = 8'd8;
	localparam logic [7:0] DEPTH_RGB  = 8'd24;
	localparam logic [7:0] DEPTH_RGBA = 8'd32;
	localparam logic [7:0] OPAQUE     = 8'hff;

	localparam logic [4:0] HDR_ID     = 5'd0;
	localparam logic [4:0] HDR_CMAP   = 5'd1;
	localparam logic [4:0] HDR_TYPE   = 5'd2;
	localparam logic [4:0] HDR_W_LO   = 5'd12;
	localparam logic [4:0] HDR_W_HI   = 5'd13;
	localparam logic [4:0] HDR_H_LO   = 5'd14;
	localparam logic [4:0] HDR_H_HI   = 5'd15;
	localparam logic [4:0] HDR_DEPTH  = 5'd16;
	localparam logic [4:0] HDR_LAST   = 5'd17;

	// quotient of a wrapped run fits in this many bits
	localparam int DIV_STEPS = 8;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	typedef struct packed {
		logic        go;
		logic [16:0] rem;
		logic [15:0] row;
	} wrap_req_t;

	typedef struct packed {
		logic        busy;
		logic        fin;
		logic [15:0] row;
		logic [15:0] col;
	} wrap_rsp_t;

endpackage

// ===== src/tga_in_if.sv =====
interface tga_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       file_start;

	modport source (output valid, output data_byte, output file_start, input ready);
	modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

// ===== src/tga_out_if.sv =====
interface tga_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [7:0]  pixel_count;
	logic [15:0] dest_row;
	logic [15:0] dest_column;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic        image_done;

	modport source (
		output valid, output status, output red, output green, output blue, output alpha,
		output pixel_count, output dest_row, output dest_column, output image_width,
		output image_height, output image_done, input ready
	);
	modport sink (
		input valid, input status, input red, input green, input blue, input alpha,
		input pixel_count, input dest_row, input dest_column, input image_width,
		input image_height, input image_done, output ready
	);
endinterface

// ===== src/tga_wrap_div.sv =====
module tga_wrap_div (
	input  logic                clk,
	input  logic                arst_n,
	input  tga_pkg::wrap_req_t  req,
	input  logic [15:0]         width,
	output tga_pkg::wrap_rsp_t  rsp
);

	logic                       busy_q;
	logic [tga_pkg::STEP_W-1:0] step_q;
	logic [16:0]                rem_q;
	logic [15:0]                row_q;
	logic [23:0]                shifted;
	logic [16:0]                rem_d;
	logic [15:0]                row_d;

	// restoring division, one quotient bit per cycle
	always_comb begin
		shifted = {8'd0, width} << step_q;
		if ({7'd0, rem_q} >= shifted) begin
			rem_d = rem_q - shifted[16:0];
			row_d = row_q - (16'd1 << step_q);
		end else begin
			rem_d = rem_q;
			row_d = row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.go) begin
			busy_q <= 1'b1;
			step_q <= tga_pkg::STEP_W'(tga_pkg::DIV_STEPS - 1);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q - tga_pkg::STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= req.rem;
			row_q <= req.row;
		end else if (busy_q) begin
			rem_q <= rem_d;
			row_q <= row_d;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.fin  = busy_q && (step_q == '0);
	assign rsp.row  = row_d;
	assign rsp.col  = rem_d[15:0];

endmodule

// ===== src/tga_image_stream_decoder.sv =====
// TGA byte stream decoder
// byte_in carries one word per file byte: data_byte and file_start, where
// file_start marks byte 0 of a new file and restarts the parser on that byte.
// pix_out carries one word per raw pixel or per run of a run-length packet:
// RGBA colour, pixel_count, destination row and column (rows fill from the
// bottom), header width and height, status and image_done. Header errors
// and empty images give a single word with image_done set on header byte 17.
// After image_done, bytes are taken and dropped until the next file_start.
// A byte taken from byte_in is registered in the input register, and its
// word in the result register. Throughput: one byte per cycle unless stalled as
// below. A run that wraps past more than one row end starts the row/column
// divider, which holds off byte_in while it finds one quotient bit per cycle.
// byte_in.ready is low while a byte waits in the input register and either
// the divider is busy or the result register is full with pix_out.ready low;
// a stalled word holds its value until taken.
// Reset empties both registers and returns the parser to the header.
module tga_image_stream_decoder (
	input  logic              clk,
	input  logic              arst_n,
	tga_in_if.sink            byte_in,
	tga_out_if.source         pix_out
);

	// input register
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        start_s1;

	// parser state
	tga_pkg::phase_t phase_q;
	logic [4:0]  hpos_q;
	logic [7:0]  id_len_q;
	logic [7:0]  cmap_q;
	logic [7:0]  itype_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [7:0]  depth_q;
	logic [7:0]  skip_q;
	logic [1:0]  bpos_q;
	logic [23:0] partial_q;
	logic [7:0]  pkt_rem_q;
	logic        pkt_run_q;
	logic [15:0] row_q;
	logic [15:0] col_q;
	logic [31:0] area_q;
	logic [31:0] left_q;

	// result register
	logic        out_valid_q;
	tga_pkg::status_t out_status_q;
	logic [7:0]  out_red_q;
	logic [7:0]  out_green_q;
	logic [7:0]  out_blue_q;
	logic [7:0]  out_alpha_q;
	logic [7:0]  out_cnt_q;
	logic [15:0] out_row_q;
	logic [15:0] out_col_q;
	logic [15:0] out_width_q;
	logic [15:0] out_height_q;
	logic        out_done_q;

	// effective and next state
	tga_pkg::phase_t e_phase, n_phase;
	logic [4:0]  e_hpos, n_hpos;
	logic [7:0]  e_id, n_id;
	logic [7:0]  e_cmap, n_cmap;
	logic [7:0]  e_type, n_type;
	logic [15:0] e_width, n_width;
	logic [15:0] e_height, n_height;
	logic [7:0]  e_depth, n_depth;
	logic [7:0]  e_skip, n_skip;
	logic [1:0]  e_bpos, n_bpos;
	logic [23:0] e_partial, n_partial;
	logic [7:0]  e_pkt_rem, n_pkt_rem;
	logic        e_run, n_run;
	logic [15:0] e_row, n_row;
	logic [15:0] e_col, n_col;
	logic [31:0] e_left, n_left;
	logic [31:0] area_d;

	logic        out_free;
	logic        adv;
	logic        step;

	logic [1:0]  last_pos;
	logic        px_ok;
	logic [23:0] px_partial;
	logic [7:0]  px_r, px_g, px_b, px_a;
	logic        pix_emit;
	logic [7:0]  emit_cnt;
	logic        img_end;
	logic [7:0]  clipped;
	logic [16:0] newcol;
	logic [16:0] width2;
	logic [16:0] col_sub;
	tga_pkg::phase_t data_ph;

	logic        res_valid;
	tga_pkg::status_t res_status;
	logic [7:0]  res_r, res_g, res_b, res_a, res_cnt;
	logic [15:0] res_row, res_col;
	logic        res_done;

	tga_pkg::wrap_req_t wrap_req;
	tga_pkg::wrap_rsp_t wrap_rsp;

	assign out_free     = !out_valid_q || pix_out.ready;
	assign adv          = out_free && !wrap_rsp.busy;
	assign step         = valid_s1 && adv;
	assign byte_in.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready) begin
			data_s1  <= byte_in.data_byte;
			start_s1 <= byte_in.file_start;
		end
	end

	always_comb begin
		if (start_s1) begin
			e_phase = tga_pkg::PH_HEADER;
			e_hpos = '0; e_id = '0; e_cmap = '0; e_type = '0;
			e_width = '0; e_height = '0; e_depth = '0; e_skip = '0;
			e_bpos = '0; e_partial = '0; e_pkt_rem = '0; e_run = 1'b0;
			e_row = '0; e_col = '0; e_left = '0;
		end else begin
			e_phase = phase_q;
			e_hpos = hpos_q; e_id = id_len_q; e_cmap = cmap_q; e_type = itype_q;
			e_width = width_q; e_height = height_q; e_depth = depth_q; e_skip = skip_q;
			e_bpos = bpos_q; e_partial = partial_q; e_pkt_rem = pkt_rem_q; e_run = pkt_run_q;
			e_row = row_q; e_col = col_q; e_left = left_q;
		end

		n_phase = e_phase;
		n_hpos = e_hpos; n_id = e_id; n_cmap = e_cmap; n_type = e_type;
		n_width = e_width; n_height = e_height; n_depth = e_depth; n_skip = e_skip;
		n_bpos = e_bpos; n_partial = e_partial; n_pkt_rem = e_pkt_rem; n_run = e_run;
		n_row = e_row; n_col = e_col; n_left = e_left;

		area_d  = {16'd0, e_width} * {16'd0, e_height};
		data_ph = (e_type == tga_pkg::TYPE_RLE) ? tga_pkg::PH_PKTHDR : tga_pkg::PH_RAW;

		// pixel assembly, bytes arrive as b, g, r, a
		if (e_depth == tga_pkg::DEPTH_GRAY) begin
			last_pos = 2'd0;
		end else if (e_depth == tga_pkg::DEPTH_RGB) begin
			last_pos = 2'd2;
		end else begin
			last_pos = 2'd3;
		end
		px_ok = (e_bpos >= last_pos);
		px_partial = e_partial;
		unique case (e_bpos)
			2'd0: px_partial[7:0]   = data_s1;
			2'd1: px_partial[15:8]  = data_s1;
			2'd2: px_partial[23:16] = data_s1;
			default: ;
		endcase
		unique case (last_pos)
			2'd0: begin
				px_r = data_s1; px_g = data_s1; px_b = data_s1; px_a = tga_pkg::OPAQUE;
			end
			2'd2: begin
				px_r = data_s1; px_g = e_partial[15:8]; px_b = e_partial[7:0];
				px_a = tga_pkg::OPAQUE;
			end
			default: begin
				px_r = e_partial[23:16]; px_g = e_partial[15:8]; px_b = e_partial[7:0];
				px_a = data_s1;
			end
		endcase

		// clip against pixels left in the image
		emit_cnt = (e_phase == tga_pkg::PH_PKTDATA && e_run) ? e_pkt_rem : 8'd1;
		img_end  = {24'd0, emit_cnt} >= e_left;
		clipped  = img_end ? e_left[7:0] : emit_cnt;
		newcol   = {1'b0, e_col} + {9'd0, clipped};
		width2   = {e_width, 1'b0};
		col_sub  = newcol - {1'b0, e_width};

		res_valid = 1'b0; res_status = tga_pkg::ST_PIXELS;
		res_r = '0; res_g = '0; res_b = '0; res_a = '0; res_cnt = '0;
		res_row = '0; res_col = '0; res_done = 1'b0;
		pix_emit = 1'b0;
		wrap_req.go  = 1'b0;
		wrap_req.rem = newcol;
		wrap_req.row = e_row;

		unique case (e_phase)
			tga_pkg::PH_HEADER: begin
				n_hpos = e_hpos + 5'd1;
				unique case (e_hpos)
					tga_pkg::HDR_ID:    n_id = data_s1;
					tga_pkg::HDR_CMAP:  n_cmap = data_s1;
					tga_pkg::HDR_TYPE:  n_type = data_s1;
					tga_pkg::HDR_W_LO:  n_width[7:0] = data_s1;
					tga_pkg::HDR_W_HI:  n_width[15:8] = data_s1;
					tga_pkg::HDR_H_LO:  n_height[7:0] = data_s1;
					tga_pkg::HDR_H_HI:  n_height[15:8] = data_s1;
					tga_pkg::HDR_DEPTH: n_depth = data_s1;
					default: ;
				endcase
				if (e_hpos == tga_pkg::HDR_LAST) begin
					res_valid = 1'b1;
					res_done  = 1'b1;
					n_phase   = tga_pkg::PH_FINISHED;
					priority if (n_type != tga_pkg::TYPE_RGB && n_type != tga_pkg::TYPE_GRAY
							&& n_type != tga_pkg::TYPE_RLE) begin
						res_status = tga_pkg::ST_BAD_TYPE;
					end else if (n_cmap != 8'd0) begin
						res_status = tga_pkg::ST_COLORMAP;
					end else if (n_depth != tga_pkg::DEPTH_RGB && n_depth != tga_pkg::DEPTH_RGBA
							&& n_type != tga_pkg::TYPE_GRAY) begin
						res_status = tga_pkg::ST_BAD_DEPTH;
					end else if (n_width == 16'd0 || n_height == 16'd0) begin
						res_status = tga_pkg::ST_PIXELS;
					end else if (n_depth != tga_pkg::DEPTH_GRAY && n_depth != tga_pkg::DEPTH_RGB
							&& n_depth != tga_pkg::DEPTH_RGBA) begin
						res_status = tga_pkg::ST_GRAY_DEPTH;
					end else begin
						res_valid = 1'b0;
						res_done  = 1'b0;
						n_row     = n_height - 16'd1;
						n_col     = '0;
						n_bpos    = '0;
						n_partial = '0;
						n_left    = area_q;
						if (n_id != 8'd0) begin
							n_skip  = n_id;
							n_phase = tga_pkg::PH_SKIP;
						end else begin
							n_phase = data_ph;
						end
					end
				end
			end
			tga_pkg::PH_SKIP: begin
				n_skip = e_skip - 8'd1;
				if (n_skip == 8'd0) begin
					n_phase = data_ph;
				end
			end
			tga_pkg::PH_RAW: begin
				if (px_ok) begin
					n_bpos   = '0;
					pix_emit = 1'b1;
					if (img_end) begin
						n_phase = tga_pkg::PH_FINISHED;
					end
				end else begin
					n_bpos    = e_bpos + 2'd1;
					n_partial = px_partial;
				end
			end
			tga_pkg::PH_PKTHDR: begin
				n_pkt_rem = {1'b0, data_s1[6:0]} + 8'd1;
				n_run     = data_s1[7];
				n_bpos    = '0;
				n_phase   = tga_pkg::PH_PKTDATA;
			end
			tga_pkg::PH_PKTDATA: begin
				if (px_ok) begin
					n_bpos   = '0;
					pix_emit = 1'b1;
					if (e_run) begin
						n_phase   = img_end ? tga_pkg::PH_FINISHED : tga_pkg::PH_PKTHDR;
						n_pkt_rem = '0;
					end else if (img_end) begin
						n_phase   = tga_pkg::PH_FINISHED;
						n_pkt_rem = '0;
					end else begin
						n_pkt_rem = e_pkt_rem - 8'd1;
						if (n_pkt_rem == 8'd0) begin
							n_phase = tga_pkg::PH_PKTHDR;
						end
					end
				end else begin
					n_bpos    = e_bpos + 2'd1;
					n_partial = px_partial;
				end
			end
			default: ;
		endcase

		if (pix_emit) begin
			res_valid = 1'b1;
			res_r = px_r; res_g = px_g; res_b = px_b; res_a = px_a;
			res_cnt  = clipped;
			res_row  = e_row;
			res_col  = e_col;
			res_done = img_end;
			n_left   = e_left - {24'd0, clipped};
			if (!img_end) begin
				if (newcol < {1'b0, e_width}) begin
					n_col = newcol[15:0];
				end else if (newcol < width2) begin
					n_col = col_sub[15:0];
					n_row = e_row - 16'd1;
				end else begin
					wrap_req.go = step;
				end
			end
		end
	end

	tga_wrap_div u_wrap_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (wrap_req),
		.width  (width_q),
		.rsp    (wrap_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tga_pkg::PH_HEADER;
			hpos_q <= '0; id_len_q <= '0; cmap_q <= '0; itype_q <= '0;
			width_q <= '0; height_q <= '0; depth_q <= '0; skip_q <= '0;
			bpos_q <= '0; partial_q <= '0; pkt_rem_q <= '0; pkt_run_q <= 1'b0;
			row_q <= '0; col_q <= '0; left_q <= '0;
		end else if (wrap_rsp.fin) begin
			row_q <= wrap_rsp.row;
			col_q <= wrap_rsp.col;
		end else if (step) begin
			phase_q <= n_phase;
			hpos_q <= n_hpos; id_len_q <= n_id; cmap_q <= n_cmap; itype_q <= n_type;
			width_q <= n_width; height_q <= n_height; depth_q <= n_depth; skip_q <= n_skip;
			bpos_q <= n_bpos; partial_q <= n_partial; pkt_rem_q <= n_pkt_rem;
			pkt_run_q <= n_run; row_q <= n_row; col_q <= n_col; left_q <= n_left;
		end
	end

	always_ff @(posedge clk) begin
		if (step && e_phase == tga_pkg::PH_HEADER && e_hpos == tga_pkg::HDR_DEPTH) begin
			area_q <= area_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_status_q <= res_status;
			out_red_q    <= res_r;
			out_green_q  <= res_g;
			out_blue_q   <= res_b;
			out_alpha_q  <= res_a;
			out_cnt_q    <= res_cnt;
			out_row_q    <= res_row;
			out_col_q    <= res_col;
			out_width_q  <= n_width;
			out_height_q <= n_height;
			out_done_q   <= res_done;
		end
	end

	assign pix_out.valid        = out_valid_q;
	assign pix_out.status       = out_status_q;
	assign pix_out.red          = out_red_q;
	assign pix_out.green        = out_green_q;
	assign pix_out.blue         = out_blue_q;
	assign pix_out.alpha        = out_alpha_q;
	assign pix_out.pixel_count  = out_cnt_q;
	assign pix_out.dest_row     = out_row_q;
	assign pix_out.dest_column  = out_col_q;
	assign pix_out.image_width  = out_width_q;
	assign pix_out.image_height = out_height_q;
	assign pix_out.image_done   = out_done_q;

	// only a run that is not clipped can need the divider, and it always leaves for a packet header
	a_div_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		wrap_rsp.busy |-> phase_q == tga_pkg::PH_PKTHDR)
		else $error("divider busy outside run packet");

	a_done_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_valid && res_done) |=> phase_q == tga_pkg::PH_FINISHED)
		else $error("image done without finishing");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!wrap_rsp.busy && (phase_q == tga_pkg::PH_RAW || phase_q == tga_pkg::PH_PKTHDR
			|| phase_q == tga_pkg::PH_PKTDATA)) |-> col_q < width_q)
		else $error("column past image width");

	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == tga_pkg::PH_RAW || phase_q == tga_pkg::PH_PKTHDR
			|| phase_q == tga_pkg::PH_PKTDATA || phase_q == tga_pkg::PH_SKIP)
			|-> left_q != 32'd0)
		else $error("pixel data phase with no pixels left");

endmodule

// ===== sim/tga_image_stream_decoder_test.sv =====
module tga_image_stream_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STREAM_BYTES = 1450;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [2:0]  status;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [7:0]  pixel_count;
		logic [15:0] dest_row;
		logic [15:0] dest_column;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        image_done;
	} pix_word_t;

	typedef struct {
		bit [7:0] value;
		bit       start;
	} file_byte_t;

	class pixel_word_board;
		tga_pkg::phase_t phase;
		bit [4:0]    hdr_pos;
		bit [7:0]    id_len;
		bit [7:0]    cmap;
		bit [7:0]    kind;
		bit [15:0]   width;
		bit [15:0]   height;
		bit [7:0]    depth;
		bit [7:0]    skip_left;
		bit [1:0]    byte_pos;
		bit [23:0]   partial;
		bit [7:0]    pkt_left;
		bit          pkt_run;
		bit [15:0]   row;
		bit [15:0]   col;
		pix_word_t   pending_pixels[$];
		int unsigned errors;
		int unsigned bytes_taken;
		int unsigned words_checked;
		int unsigned headers_parsed;
		int unsigned header_stops;

		function new();
			clear();
		endfunction

		function void clear();
			phase = tga_pkg::PH_HEADER;
			hdr_pos = 5'd0;
			id_len = 8'd0;
			cmap = 8'd0;
			kind = 8'd0;
			width = 16'd0;
			height = 16'd0;
			depth = 8'd0;
			skip_left = 8'd0;
			byte_pos = 2'd0;
			partial = 24'd0;
			pkt_left = 8'd0;
			pkt_run = 1'b0;
			row = 16'd0;
			col = 16'd0;
		endfunction

		function void push_word(tga_pkg::status_t st, bit [7:0] r, g, bl, a, cnt,
				bit [15:0] at_row, at_col, bit done);
			pix_word_t w;
			w.status = st;
			w.red = r;
			w.green = g;
			w.blue = bl;
			w.alpha = a;
			w.pixel_count = cnt;
			w.dest_row = at_row;
			w.dest_column = at_col;
			w.image_width = width;
			w.image_height = height;
			w.image_done = done;
			pending_pixels.push_back(w);
		endfunction

		function void finish_with(tga_pkg::status_t st);
			phase = tga_pkg::PH_FINISHED;
			header_stops++;
			push_word(st, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 1'b1);
		endfunction

		// place cnt pixels of one colour, clipped at the image end
		function bit place_run(int unsigned cnt, bit [7:0] r, g, bl, a);
			longint unsigned left;
			longint unsigned taken;
			longint unsigned next_col;
			bit done;
			if (width == 16'd0 || col >= width) begin
				push_word(tga_pkg::ST_PIXELS, r, g, bl, a, 8'd0, row, col, 1'b1);
				return 1'b1;
			end
			left = 64'(row) * 64'(width) + 64'(width - col);
			taken = 64'(cnt);
			if (taken > left)
				taken = left;
			done = (taken == left);
			push_word(tga_pkg::ST_PIXELS, r, g, bl, a, taken[7:0], row, col, done);
			if (!done) begin
				next_col = 64'(col) + taken;
				row = 16'(64'(row) - next_col / 64'(width));
				col = 16'(next_col % 64'(width));
			end
			return done;
		endfunction

		function bit take_pixel_byte(bit [7:0] b, output bit [7:0] r, g, bl, a);
			int unsigned bpp;
			bpp = (depth == tga_pkg::DEPTH_GRAY) ? 1 : (depth == tga_pkg::DEPTH_RGB) ? 3 : 4;
			r = 8'd0;
			g = 8'd0;
			bl = 8'd0;
			a = 8'd0;
			if (byte_pos + 1 < bpp) begin
				partial[8 * byte_pos +: 8] = b;
				byte_pos++;
				return 1'b0;
			end
			byte_pos = 2'd0;
			case (bpp)
				1: begin
					r = b;
					g = b;
					bl = b;
					a = tga_pkg::OPAQUE;
				end
				3: begin
					bl = partial[7:0];
					g = partial[15:8];
					r = b;
					a = tga_pkg::OPAQUE;
				end
				default: begin
					bl = partial[7:0];
					g = partial[15:8];
					r = partial[23:16];
					a = b;
				end
			endcase
			return 1'b1;
		endfunction

		function void take_file_byte(bit [7:0] b, bit start);
			bit [4:0] pos;
			bit [7:0] r, g, bl, a;
			bytes_taken++;
			if (start)
				clear();
			case (phase)
				tga_pkg::PH_HEADER: begin
					pos = hdr_pos;
					hdr_pos++;
					case (pos)
						tga_pkg::HDR_ID: id_len = b;
						tga_pkg::HDR_CMAP: cmap = b;
						tga_pkg::HDR_TYPE: kind = b;
						tga_pkg::HDR_W_LO: width[7:0] = b;
						tga_pkg::HDR_W_HI: width[15:8] = b;
						tga_pkg::HDR_H_LO: height[7:0] = b;
						tga_pkg::HDR_H_HI: height[15:8] = b;
						tga_pkg::HDR_DEPTH: depth = b;
						default: ;
					endcase
					if (pos == tga_pkg::HDR_LAST) begin
						headers_parsed++;
						if (kind != tga_pkg::TYPE_RGB && kind != tga_pkg::TYPE_GRAY
								&& kind != tga_pkg::TYPE_RLE)
							finish_with(tga_pkg::ST_BAD_TYPE);
						else if (cmap != 8'd0)
							finish_with(tga_pkg::ST_COLORMAP);
						else if (depth != tga_pkg::DEPTH_RGB && depth != tga_pkg::DEPTH_RGBA
								&& kind != tga_pkg::TYPE_GRAY)
							finish_with(tga_pkg::ST_BAD_DEPTH);
						else if (width == 16'd0 || height == 16'd0)
							finish_with(tga_pkg::ST_PIXELS);
						else if (depth != tga_pkg::DEPTH_GRAY && depth != tga_pkg::DEPTH_RGB
								&& depth != tga_pkg::DEPTH_RGBA)
							finish_with(tga_pkg::ST_GRAY_DEPTH);
						else begin
							row = height - 16'd1;
							col = 16'd0;
							byte_pos = 2'd0;
							partial = 24'd0;
							if (id_len != 8'd0) begin
								skip_left = id_len;
								phase = tga_pkg::PH_SKIP;
							end else begin
								phase = (kind == tga_pkg::TYPE_RLE) ? tga_pkg::PH_PKTHDR
									: tga_pkg::PH_RAW;
							end
						end
					end
				end
				tga_pkg::PH_SKIP: begin
					skip_left--;
					if (skip_left == 8'd0)
						phase = (kind == tga_pkg::TYPE_RLE) ? tga_pkg::PH_PKTHDR
							: tga_pkg::PH_RAW;
				end
				tga_pkg::PH_RAW: begin
					if (take_pixel_byte(b, r, g, bl, a))
						if (place_run(1, r, g, bl, a))
							phase = tga_pkg::PH_FINISHED;
				end
				tga_pkg::PH_PKTHDR: begin
					pkt_left = {1'b0, b[6:0]} + 8'd1;
					pkt_run = b[7];
					byte_pos = 2'd0;
					phase = tga_pkg::PH_PKTDATA;
				end
				tga_pkg::PH_PKTDATA: begin
					if (take_pixel_byte(b, r, g, bl, a)) begin
						if (pkt_run) begin
							phase = place_run(32'(pkt_left), r, g, bl, a) ? tga_pkg::PH_FINISHED
								: tga_pkg::PH_PKTHDR;
							pkt_left = 8'd0;
						end else if (place_run(1, r, g, bl, a)) begin
							phase = tga_pkg::PH_FINISHED;
							pkt_left = 8'd0;
						end else begin
							pkt_left--;
							if (pkt_left == 8'd0)
								phase = tga_pkg::PH_PKTHDR;
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_pixel_word(pix_word_t got);
			pix_word_t want;
			words_checked++;
			if (pending_pixels.size() == 0) begin
				$error("pixel word with nothing pending: status %0d row %0d column %0d",
					got.status, got.dest_row, got.dest_column);
				errors++;
				return;
			end
			want = pending_pixels.pop_front();
			compare_field("status", 16'(want.status), 16'(got.status));
			compare_field("red", 16'(want.red), 16'(got.red));
			compare_field("green", 16'(want.green), 16'(got.green));
			compare_field("blue", 16'(want.blue), 16'(got.blue));
			compare_field("alpha", 16'(want.alpha), 16'(got.alpha));
			compare_field("pixel_count", 16'(want.pixel_count), 16'(got.pixel_count));
			compare_field("dest_row", want.dest_row, got.dest_row);
			compare_field("dest_column", want.dest_column, got.dest_column);
			compare_field("image_width", want.image_width, got.image_width);
			compare_field("image_height", want.image_height, got.image_height);
			compare_field("image_done", 16'(want.image_done), 16'(got.image_done));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tga_in_if byte_in_bus();
	tga_out_if pix_out_bus();

	tga_image_stream_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_in(byte_in_bus),
		.pix_out(pix_out_bus)
	);

	pixel_word_board board;
	file_byte_t stream[$];
	pix_word_t seen_word;
	int unsigned words_seen = 0;
	int unsigned cycle_count = 0;
	int unsigned tx_calm = 0;
	int unsigned rx_calm = 0;
	bit hold_active = 1'b0;
	bit hold_done = 1'b0;

	function automatic int unsigned pick_pause(inout int unsigned calm_left);
		int unsigned roll;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		roll = $urandom_range(0, 999);
		if (roll < 4)
			calm_left = $urandom_range(100, 300);
		if (roll < 700)
			return 0;
		if (roll < 960)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void put_byte(bit [7:0] v, bit s = 1'b0);
		file_byte_t fb;
		fb.value = v;
		fb.start = s;
		stream.push_back(fb);
	endfunction

	function automatic void put_random_bytes(int unsigned n);
		repeat (n) put_byte(8'($urandom));
	endfunction

	function automatic void put_header(bit [7:0] id_len, cmap, kind, bit [15:0] w, h,
			bit [7:0] depth, bit marked = 1'b1);
		put_byte(id_len, marked);
		put_byte(cmap);
		put_byte(kind);
		put_random_bytes(9);
		put_byte(w[7:0]);
		put_byte(w[15:8]);
		put_byte(h[7:0]);
		put_byte(h[15:8]);
		put_byte(depth);
		put_random_bytes(1);
		put_random_bytes(32'(id_len));
	endfunction

	task automatic send_byte(input file_byte_t fb);
		int unsigned gap;
		gap = hold_active ? 0 : pick_pause(tx_calm);
		if (gap > 0) begin
			byte_in_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_in_bus.valid <= 1'b1;
		byte_in_bus.data_byte <= fb.value;
		byte_in_bus.file_start <= fb.start;
		@(negedge clk);
		while (!byte_in_bus.ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n === 1'b1) begin
			if (byte_in_bus.valid && byte_in_bus.ready)
				board.take_file_byte(byte_in_bus.data_byte, byte_in_bus.file_start);
			if (pix_out_bus.valid && pix_out_bus.ready) begin
				seen_word.status = pix_out_bus.status;
				seen_word.red = pix_out_bus.red;
				seen_word.green = pix_out_bus.green;
				seen_word.blue = pix_out_bus.blue;
				seen_word.alpha = pix_out_bus.alpha;
				seen_word.pixel_count = pix_out_bus.pixel_count;
				seen_word.dest_row = pix_out_bus.dest_row;
				seen_word.dest_column = pix_out_bus.dest_column;
				seen_word.image_width = pix_out_bus.image_width;
				seen_word.image_height = pix_out_bus.image_height;
				seen_word.image_done = pix_out_bus.image_done;
				board.check_pixel_word(seen_word);
				words_seen++;
			end
		end
	end

	// output side: random stalls plus one long hold while input keeps coming
	initial begin : drain
		int unsigned pause;
		pix_out_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			pause = pick_pause(rx_calm);
			if (!hold_done && words_seen >= 150) begin
				pause = HOLD_CYCLES;
				hold_done = 1'b1;
				hold_active = 1'b1;
			end
			if (pause > 0) begin
				pix_out_bus.ready <= 1'b0;
				repeat (pause) @(posedge clk);
				hold_active = 1'b0;
			end
			pix_out_bus.ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : stimulus
		int unsigned pick;
		int unsigned w;
		int unsigned h;
		int unsigned bpp;
		int unsigned pixels;
		int unsigned top;
		int unsigned len;
		int unsigned mark;
		bit [7:0] kind;
		bit [7:0] depth;
		bit [7:0] id_len;
		bit [7:0] cmap;
		bit [7:0] depth_pick [4];
		bit run;
		bit overrun;

		board = new();
		byte_in_bus.valid = 1'b0;
		byte_in_bus.data_byte = 8'd0;
		byte_in_bus.file_start = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// raw colour right after reset, first byte unmarked, id field skipped
		put_header(8'd2, 8'd0, tga_pkg::TYPE_RGB, 16'd2, 16'd2, tga_pkg::DEPTH_RGB, 1'b0);
		put_random_bytes(12);
		// 32-bit pixels at both ends of the byte range
		put_header(8'd0, 8'd0, tga_pkg::TYPE_RGB, 16'd3, 16'd1, tga_pkg::DEPTH_RGBA);
		repeat (4) put_byte(8'h00);
		repeat (4) put_byte(8'hff);
		put_random_bytes(4);
		// gray, then bytes after completion
		put_header(8'd0, 8'd0, tga_pkg::TYPE_GRAY, 16'd3, 16'd1, tga_pkg::DEPTH_GRAY);
		put_byte(8'h00);
		put_byte(8'hff);
		put_byte(8'h5a);
		put_random_bytes(3);
		// gray type carrying colour pixels
		put_header(8'd1, 8'd0, tga_pkg::TYPE_GRAY, 16'd1, 16'd1, tga_pkg::DEPTH_RGBA);
		put_random_bytes(4);
		// run of 128 clipped at the image end
		put_header(8'd0, 8'd0, tga_pkg::TYPE_RLE, 16'd4, 16'd3, tga_pkg::DEPTH_RGB);
		put_byte(8'hff);
		put_random_bytes(3);
		// raw packet, run packet, raw packet running past the end
		put_header(8'd0, 8'd0, tga_pkg::TYPE_RLE, 16'd3, 16'd2, tga_pkg::DEPTH_RGBA);
		put_byte(8'h01);
		put_random_bytes(8);
		put_byte(8'h81);
		put_random_bytes(4);
		put_byte(8'h02);
		put_random_bytes(12);
		// long runs wrapping many rows, the last clipped at the image end
		put_header(8'd0, 8'd0, tga_pkg::TYPE_RLE, 16'd5, 16'd40, tga_pkg::DEPTH_RGB);
		put_byte(8'hff);
		put_random_bytes(3);
		put_byte(8'h80);
		put_random_bytes(3);
		put_byte(8'hfe);
		put_random_bytes(3);
		// header rejects and empty images
		put_header(8'd0, 8'd0, 8'd1, 16'd4, 16'd4, tga_pkg::DEPTH_RGB);
		put_header(8'd0, 8'd1, tga_pkg::TYPE_RGB, 16'd4, 16'd4, tga_pkg::DEPTH_RGB);
		put_header(8'd0, 8'hff, 8'hff, 16'd4, 16'd4, 8'd16);
		put_header(8'd0, 8'd0, tga_pkg::TYPE_RGB, 16'd4, 16'd4, 8'd16);
		put_header(8'd0, 8'd0, tga_pkg::TYPE_RLE, 16'd4, 16'd4, tga_pkg::DEPTH_GRAY);
		put_header(8'd0, 8'd0, tga_pkg::TYPE_GRAY, 16'd4, 16'd4, 8'd16);
		put_header(8'd0, 8'd0, tga_pkg::TYPE_RGB, 16'd0, 16'd4, tga_pkg::DEPTH_RGB);
		put_header(8'd0, 8'd0, tga_pkg::TYPE_GRAY, 16'd4, 16'd0, 8'd16);
		// widest and tallest image behind the longest id field
		put_header(8'hff, 8'd0, tga_pkg::TYPE_RGB, 16'hffff, 16'hffff, tga_pkg::DEPTH_RGBA);
		put_random_bytes(12);
		// restart in the middle of a header
		put_byte(8'h00, 1'b1);
		put_byte(8'h00);
		put_byte(tga_pkg::TYPE_RGB);
		put_header(8'd0, 8'd0, tga_pkg::TYPE_RGB, 16'd1, 16'd1, tga_pkg::DEPTH_RGB);
		put_random_bytes(7);

		depth_pick = '{tga_pkg::DEPTH_GRAY, 8'd16, tga_pkg::DEPTH_RGB, tga_pkg::DEPTH_RGBA};
		while (stream.size() < STREAM_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				kind = (pick < 27) ? tga_pkg::TYPE_RLE : (pick < 52) ? tga_pkg::TYPE_RGB
					: tga_pkg::TYPE_GRAY;
				if (kind == tga_pkg::TYPE_GRAY && $urandom_range(0, 3) != 0)
					depth = tga_pkg::DEPTH_GRAY;
				else
					depth = $urandom_range(0, 1) ? tga_pkg::DEPTH_RGBA : tga_pkg::DEPTH_RGB;
				w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				h = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
				id_len = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 4)) : 8'd0;
				put_header(id_len, 8'd0, kind, 16'(w), 16'(h), depth);
				mark = stream.size();
				bpp = (depth == tga_pkg::DEPTH_GRAY) ? 1 : (depth == tga_pkg::DEPTH_RGB) ? 3 : 4;
				pixels = w * h;
				if (kind == tga_pkg::TYPE_RLE) begin
					overrun = ($urandom_range(0, 3) == 0);
					while (pixels > 0) begin
						top = (overrun || pixels > 128) ? 128 : pixels;
						len = $urandom_range(0, 1) ? $urandom_range(1, (top < 4) ? top : 4)
							: $urandom_range(1, top);
						run = $urandom_range(0, 1);
						put_byte({run, 7'(len - 1)});
						put_random_bytes(run ? bpp : len * bpp);
						pixels = (len >= pixels) ? 0 : pixels - len;
					end
				end else begin
					put_random_bytes(pixels * bpp);
				end
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(1, stream.size() - mark)) void'(stream.pop_back());
				if ($urandom_range(0, 6) == 0)
					put_random_bytes($urandom_range(1, 6));
			end else if (pick < 90) begin
				case ($urandom_range(0, 4))
					0: kind = 8'($urandom);
					1: kind = tga_pkg::TYPE_RGB;
					2: kind = tga_pkg::TYPE_GRAY;
					3: kind = tga_pkg::TYPE_RLE;
					default: kind = 8'($urandom_range(0, 15));
				endcase
				cmap = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'd0;
				depth = $urandom_range(0, 1) ? 8'($urandom)
					: depth_pick[2'($urandom_range(0, 3))];
				w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535);
				h = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535);
				put_header(8'd0, cmap, kind, 16'(w), 16'(h), depth);
			end else begin
				repeat ($urandom_range(1, 20))
					put_byte(8'($urandom), $urandom_range(0, 7) == 0);
			end
		end
		while (stream.size() > STREAM_BYTES)
			void'(stream.pop_back());

		foreach (stream[i])
			send_byte(stream[i]);
		byte_in_bus.valid <= 1'b0;

		while (board.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("decoded %0d file bytes into %0d pixel words over %0d parsed headers",
			board.bytes_taken, board.words_checked, board.headers_parsed);
		$display("%0d headers stopped at the last header byte; output held off once for %0d cycles",
			board.header_stops, HOLD_CYCLES);
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
src/tga_pkg.sv
src/tga_in_if.sv
src/tga_out_if.sv
src/tga_wrap_div.sv
src/tga_image_stream_decoder.sv
sim/tga_image_stream_decoder_test.sv
